### rtl/core/i2c_master_byte_writer_assert.svh
// ----------------------------------------------------------------------------
// i2c_master_byte_writer assertion macros
// Shorthand for clocked checks, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_WRITER_ASSERT_SVH
`define I2C_MASTER_BYTE_WRITER_ASSERT_SVH

// Same-cycle implication.
`define I2CMBW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define I2CMBW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/i2cmbw_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbw_pkg
// Types and constants shared by the I2C byte writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cmbw_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;

  localparam logic [7:0] ADDR_RESET  = 8'h48;
  localparam logic [7:0] DELAY_RESET = 8'd1;
  localparam logic [3:0] DATA_HIGH_NIBBLE = 4'h1;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS  = 2'd1;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_BEGIN = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START     = 4'd1,
    PH_LOW       = 4'd2,
    PH_SETUP     = 4'd3,
    PH_HWAIT     = 4'd4,
    PH_HHOLD     = 4'd5,
    PH_STOP_LOW  = 4'd6,
    PH_STOP_WAIT = 4'd7,
    PH_STOP_HIGH = 4'd8,
    PH_STOP_END  = 4'd9
  } phase_t;

  typedef struct packed {
    logic       opcode;
    logic [3:0] tone;
    logic       scl_sense;
    logic       sda_sense;
  } in_item_t;

  typedef struct packed {
    logic scl_release;
    logic sda_release;
    logic busy_res;
    logic no_ack;
    logic bus_fault;
    logic done_res;
  } out_item_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] bit_count;
    logic [7:0] shift_byte;
    logic [7:0] second_byte;
    logic       byte_index;
    logic [7:0] wait_count;
    logic       nack_flag;
    logic       fault_flag;
    logic       scl_level;
    logic       sda_level;
  } seq_state_t;

  typedef struct packed {
    logic [7:0] address_byte;
    logic [7:0] delay_ticks;
  } cfg_regs_t;

endpackage

`default_nettype wire

### rtl/core/i2cmbw_step.sv
// ----------------------------------------------------------------------------
// i2cmbw_step
// One tick of the bus sequencer: next state and result from current state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cmbw_step (
  input  var i2cmbw_pkg::seq_state_t st,
  input  var i2cmbw_pkg::cfg_regs_t  cfg,
  input  var i2cmbw_pkg::in_item_t   item,
  output     i2cmbw_pkg::seq_state_t st_nxt,
  output     i2cmbw_pkg::out_item_t  res
);

  localparam logic [3:0] BIT_LAST = 4'(i2cmbw_pkg::BITS_PER_BYTE);
  localparam logic [3:0] BIT_STOP = 4'(i2cmbw_pkg::BITS_PER_BYTE + 1);

  logic [7:0] dly_eff;
  logic       hold_done;
  logic [7:0] wait_held;
  logic       nack_acc;
  logic       bus_idle;

  // Shared hold counter: zero delay behaves as one.
  always_comb begin
    dly_eff   = (cfg.delay_ticks == 8'd0) ? 8'd1 : cfg.delay_ticks;
    hold_done = ({1'b0, st.wait_count} + 9'd1) >= {1'b0, dly_eff};
    wait_held = hold_done ? 8'd0 : st.wait_count + 8'd1;
    nack_acc  = st.nack_flag | item.sda_sense;
    bus_idle  = item.scl_sense & item.sda_sense;
  end

  // Next state
  always_comb begin
    st_nxt = st;
    unique case (st.phase)
      i2cmbw_pkg::PH_IDLE: begin
        st_nxt.scl_level = 1'b1;
        st_nxt.sda_level = 1'b1;
        if (item.opcode == i2cmbw_pkg::OP_BEGIN) begin
          st_nxt.nack_flag  = 1'b0;
          st_nxt.fault_flag = ~bus_idle;
          if (bus_idle) begin
            st_nxt.second_byte = {i2cmbw_pkg::DATA_HIGH_NIBBLE, item.tone};
            st_nxt.shift_byte  = cfg.address_byte;
            st_nxt.byte_index  = 1'b0;
            st_nxt.bit_count   = 4'd0;
            st_nxt.wait_count  = 8'd0;
            st_nxt.sda_level   = 1'b0;
            st_nxt.phase       = i2cmbw_pkg::PH_START;
          end
        end
      end
      i2cmbw_pkg::PH_START: begin
        st_nxt.wait_count = wait_held;
        if (hold_done) begin
          st_nxt.scl_level = 1'b0;
          st_nxt.phase     = i2cmbw_pkg::PH_LOW;
        end
      end
      i2cmbw_pkg::PH_LOW: begin
        st_nxt.wait_count = wait_held;
        if (hold_done) begin
          if (st.bit_count < BIT_LAST) begin
            st_nxt.sda_level = st.shift_byte[7];
            st_nxt.phase     = i2cmbw_pkg::PH_SETUP;
          end else if (st.bit_count == BIT_LAST) begin
            st_nxt.sda_level = 1'b1;
            st_nxt.phase     = i2cmbw_pkg::PH_SETUP;
          end else begin
            st_nxt.sda_level = 1'b0;
            st_nxt.phase     = i2cmbw_pkg::PH_STOP_LOW;
          end
        end
      end
      i2cmbw_pkg::PH_SETUP: begin
        st_nxt.wait_count = wait_held;
        if (hold_done) begin
          st_nxt.scl_level = 1'b1;
          st_nxt.phase     = i2cmbw_pkg::PH_HWAIT;
        end
      end
      i2cmbw_pkg::PH_HWAIT: begin
        // hold until the slave lets the clock go high
        if (item.scl_sense) begin
          st_nxt.wait_count = 8'd0;
          st_nxt.phase      = i2cmbw_pkg::PH_HHOLD;
        end
      end
      i2cmbw_pkg::PH_HHOLD: begin
        st_nxt.wait_count = wait_held;
        if (hold_done) begin
          if (st.bit_count < BIT_LAST) begin
            st_nxt.shift_byte = {st.shift_byte[6:0], 1'b0};
            st_nxt.bit_count  = st.bit_count + 4'd1;
          end else begin
            st_nxt.nack_flag = nack_acc;
            if (!nack_acc && !st.byte_index) begin
              st_nxt.byte_index = 1'b1;
              st_nxt.shift_byte = st.second_byte;
              st_nxt.bit_count  = 4'd0;
            end else begin
              st_nxt.bit_count = BIT_STOP;
            end
          end
          st_nxt.scl_level = 1'b0;
          st_nxt.phase     = i2cmbw_pkg::PH_LOW;
        end
      end
      i2cmbw_pkg::PH_STOP_LOW: begin
        st_nxt.wait_count = wait_held;
        if (hold_done) begin
          st_nxt.scl_level = 1'b1;
          st_nxt.phase     = i2cmbw_pkg::PH_STOP_WAIT;
        end
      end
      i2cmbw_pkg::PH_STOP_WAIT: begin
        if (item.scl_sense) begin
          st_nxt.wait_count = 8'd0;
          st_nxt.phase      = i2cmbw_pkg::PH_STOP_HIGH;
        end
      end
      i2cmbw_pkg::PH_STOP_HIGH: begin
        st_nxt.wait_count = wait_held;
        if (hold_done) begin
          st_nxt.sda_level = 1'b1;
          st_nxt.phase     = i2cmbw_pkg::PH_STOP_END;
        end
      end
      i2cmbw_pkg::PH_STOP_END: begin
        st_nxt.wait_count = wait_held;
        if (hold_done) begin
          st_nxt.phase = i2cmbw_pkg::PH_IDLE;
        end
      end
      default: begin
        st_nxt.phase      = i2cmbw_pkg::PH_IDLE;
        st_nxt.scl_level  = 1'b1;
        st_nxt.sda_level  = 1'b1;
        st_nxt.wait_count = 8'd0;
      end
    endcase
  end

  // Result
  always_comb begin
    res.scl_release = st_nxt.scl_level;
    res.sda_release = st_nxt.sda_level;
    res.busy_res    = (st_nxt.phase != i2cmbw_pkg::PH_IDLE);
    res.no_ack      = st_nxt.nack_flag;
    res.bus_fault   = st_nxt.fault_flag;
    res.done_res    = ((st.phase == i2cmbw_pkg::PH_IDLE) &&
                       (item.opcode == i2cmbw_pkg::OP_BEGIN) && !bus_idle) ||
                      ((st.phase == i2cmbw_pkg::PH_STOP_END) && hold_done);
  end

endmodule

`default_nettype wire

### rtl/core/i2c_master_byte_writer.sv
// Tick-driven I2C master that writes an address byte and one tone byte.
// Input channel (in_valid/in_stall/in_data): each transfer is one sequencer
// tick carrying the opcode (plain tick or begin), the tone and the sampled
// SCL/SDA levels. Result channel (out_valid/out_stall/out_data): exactly one
// result per tick with the line releases and busy/no_ack/bus_fault/done.
// An accepted tick's result is in the output register in the next cycle;
// one tick is taken every cycle while the receiver does not stall, as the
// state update from sequencer state to result register is combinational.
// When the receiver stalls, the held result stays put and in_stall rises in
// the same cycle, so no tick is taken until the result is transferred.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the
// address byte, index 1 the hold length in ticks; other indexes are dropped.
// cfg_ready is always high. Write only while the master is idle.
// Reset (synchronous, rst_n low): sequencer idle with both lines released,
// flags clear, address 0x48, hold length 1, no result pending.
// ----------------------------------------------------------------------------
// i2c_master_byte_writer
// Top level: config registers, sequencer state and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_byte_writer_assert.svh"

module i2c_master_byte_writer (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire                                       in_valid,
  output logic                                      in_stall,
  input  var i2cmbw_pkg::in_item_t                  in_data,
  output logic                                      out_valid,
  input  wire                                       out_stall,
  output     i2cmbw_pkg::out_item_t                 out_data,
  input  wire                                       cfg_valid,
  output logic                                      cfg_ready,
  input  wire [i2cmbw_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire [7:0]                                 cfg_data
);

  i2cmbw_pkg::cfg_regs_t  cfg_r, cfg_nxt;
  i2cmbw_pkg::seq_state_t st_r, st_nxt;
  i2cmbw_pkg::seq_state_t st_step;
  i2cmbw_pkg::out_item_t  res_step;
  i2cmbw_pkg::out_item_t  out_data_r, out_data_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   in_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_take   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  i2cmbw_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (in_data),
    .st_nxt (st_step),
    .res    (res_step)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        i2cmbw_pkg::REG_ADDRESS_BYTE: cfg_nxt.address_byte = cfg_data;
        i2cmbw_pkg::REG_DELAY_TICKS:  cfg_nxt.delay_ticks  = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt        = in_take ? st_step : st_r;
    out_data_nxt  = in_take ? res_step : out_data_r;
    // drop the result once transferred unless a new one replaces it
    out_valid_nxt = in_take | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.address_byte <= i2cmbw_pkg::ADDR_RESET;
      cfg_r.delay_ticks  <= i2cmbw_pkg::DELAY_RESET;
      st_r.phase         <= i2cmbw_pkg::PH_IDLE;
      st_r.bit_count     <= 4'd0;
      st_r.shift_byte    <= 8'd0;
      st_r.second_byte   <= 8'd0;
      st_r.byte_index    <= 1'b0;
      st_r.wait_count    <= 8'd0;
      st_r.nack_flag     <= 1'b0;
      st_r.fault_flag    <= 1'b0;
      st_r.scl_level     <= 1'b1;
      st_r.sda_level     <= 1'b1;
      out_valid_r        <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `I2CMBW_ASSERT_NOW(a_idle_lines_released, out_valid_r && !out_data_r.busy_res, out_data_r.scl_release && out_data_r.sda_release, "lines driven while not busy")
  `I2CMBW_ASSERT_NOW(a_done_not_busy, out_valid_r && out_data_r.done_res, !out_data_r.busy_res, "done pulse while still busy")
  `I2CMBW_ASSERT_NOW(a_idle_wait_clear, st_r.phase == i2cmbw_pkg::PH_IDLE, st_r.wait_count == 8'd0, "hold counter left running in idle")
  `I2CMBW_ASSERT_NEXT(a_take_shows_result, in_take, out_valid_r, "accepted tick produced no result")

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tick-driven I2C byte writer. Ticks are queued
// by a stimulus process, offered by a driver with random gaps and checked
// against an in-bench model of the bus sequencer, one result per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam logic [i2cmbw_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [i2cmbw_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  i2cmbw_pkg::in_item_t                 in_data = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  i2cmbw_pkg::out_item_t                out_data;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [i2cmbw_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [7:0]                           cfg_data = '0;

  i2c_master_byte_writer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Bench copy of the sequencer state and its registers
  i2cmbw_pkg::phase_t seq_ph     = i2cmbw_pkg::PH_IDLE;
  logic [3:0]         bits_sent  = '0;
  logic [7:0]         sreg       = '0;
  logic [7:0]         data_byte  = '0;
  logic               on_data    = 1'b0;
  logic [7:0]         hold_cnt   = '0;
  logic               nack_seen  = 1'b0;
  logic               fault_seen = 1'b0;
  logic               scl_out    = 1'b1;
  logic               sda_out    = 1'b1;
  logic [7:0]         addr_cfg   = i2cmbw_pkg::ADDR_RESET;
  logic [7:0]         delay_cfg  = i2cmbw_pkg::DELAY_RESET;

  i2cmbw_pkg::in_item_t  pending_ticks[$];
  i2cmbw_pkg::out_item_t expected_lines[$];

  int   fail_cnt = 0;
  int   quiet_cycles = 0;
  logic in_acc = 1'b0;
  logic out_acc = 1'b0;
  int   in_gap = 0;
  int   in_gap_max = 10;
  int   out_gap_max = 10;
  int   rx_wait = 0;
  int   rx_hold = 0;
  logic hold_ask = 1'b0;
  logic hold_seen = 1'b0;

  function automatic logic hold_done();
    int span;
    span = (delay_cfg == 8'd0) ? 1 : int'(delay_cfg);
    if (int'(hold_cnt) + 1 >= span) begin
      hold_cnt = 8'd0;
      return 1'b1;
    end
    hold_cnt = hold_cnt + 8'd1;
    return 1'b0;
  endfunction

  function automatic i2cmbw_pkg::out_item_t predict_bus_tick(i2cmbw_pkg::in_item_t t);
    i2cmbw_pkg::out_item_t r;
    logic                  ends;
    ends = 1'b0;
    case (seq_ph)
      i2cmbw_pkg::PH_IDLE: begin
        scl_out = 1'b1;
        sda_out = 1'b1;
        if (t.opcode == i2cmbw_pkg::OP_BEGIN) begin
          nack_seen  = 1'b0;
          fault_seen = 1'b0;
          if (t.scl_sense && t.sda_sense) begin
            data_byte = {i2cmbw_pkg::DATA_HIGH_NIBBLE, t.tone};
            sreg      = addr_cfg;
            on_data   = 1'b0;
            bits_sent = '0;
            hold_cnt  = '0;
            sda_out   = 1'b0;
            seq_ph    = i2cmbw_pkg::PH_START;
          end else begin
            fault_seen = 1'b1;
            ends       = 1'b1;
          end
        end
      end
      i2cmbw_pkg::PH_START: begin
        if (hold_done()) begin
          scl_out = 1'b0;
          seq_ph  = i2cmbw_pkg::PH_LOW;
        end
      end
      i2cmbw_pkg::PH_LOW: begin
        if (hold_done()) begin
          if (bits_sent < i2cmbw_pkg::BITS_PER_BYTE) begin
            sda_out = sreg[7];
            seq_ph  = i2cmbw_pkg::PH_SETUP;
          end else if (bits_sent == i2cmbw_pkg::BITS_PER_BYTE) begin
            // release SDA for the acknowledge clock
            sda_out = 1'b1;
            seq_ph  = i2cmbw_pkg::PH_SETUP;
          end else begin
            sda_out = 1'b0;
            seq_ph  = i2cmbw_pkg::PH_STOP_LOW;
          end
        end
      end
      i2cmbw_pkg::PH_SETUP: begin
        if (hold_done()) begin
          scl_out = 1'b1;
          seq_ph  = i2cmbw_pkg::PH_HWAIT;
        end
      end
      i2cmbw_pkg::PH_HWAIT: begin
        if (t.scl_sense) begin
          hold_cnt = '0;
          seq_ph   = i2cmbw_pkg::PH_HHOLD;
        end
      end
      i2cmbw_pkg::PH_HHOLD: begin
        if (hold_done()) begin
          if (bits_sent < i2cmbw_pkg::BITS_PER_BYTE) begin
            sreg      = {sreg[6:0], 1'b0};
            bits_sent = bits_sent + 4'd1;
          end else begin
            if (t.sda_sense) nack_seen = 1'b1;
            if (!nack_seen && !on_data) begin
              on_data   = 1'b1;
              sreg      = data_byte;
              bits_sent = '0;
            end else begin
              // skip to stop
              bits_sent = 4'(i2cmbw_pkg::BITS_PER_BYTE + 1);
            end
          end
          scl_out = 1'b0;
          seq_ph  = i2cmbw_pkg::PH_LOW;
        end
      end
      i2cmbw_pkg::PH_STOP_LOW: begin
        if (hold_done()) begin
          scl_out = 1'b1;
          seq_ph  = i2cmbw_pkg::PH_STOP_WAIT;
        end
      end
      i2cmbw_pkg::PH_STOP_WAIT: begin
        if (t.scl_sense) begin
          hold_cnt = '0;
          seq_ph   = i2cmbw_pkg::PH_STOP_HIGH;
        end
      end
      i2cmbw_pkg::PH_STOP_HIGH: begin
        if (hold_done()) begin
          sda_out = 1'b1;
          seq_ph  = i2cmbw_pkg::PH_STOP_END;
        end
      end
      i2cmbw_pkg::PH_STOP_END: begin
        if (hold_done()) begin
          seq_ph = i2cmbw_pkg::PH_IDLE;
          ends   = 1'b1;
        end
      end
      default: begin
        seq_ph   = i2cmbw_pkg::PH_IDLE;
        scl_out  = 1'b1;
        sda_out  = 1'b1;
        hold_cnt = '0;
      end
    endcase
    r.scl_release = scl_out;
    r.sda_release = sda_out;
    r.busy_res    = (seq_ph != i2cmbw_pkg::PH_IDLE);
    r.no_ack      = nack_seen;
    r.bus_fault   = fault_seen;
    r.done_res    = ends;
    return r;
  endfunction

  task automatic check_field(string name, logic e, logic a);
    if (a !== e) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fail_cnt++;
    end
  endtask

  // Monitor: model update, result check and watchdog, all at the rising edge
  always @(posedge clk) begin
    i2cmbw_pkg::out_item_t e;
    if (!rst_n) begin
      in_acc  <= 1'b0;
      out_acc <= 1'b0;
    end else begin
      in_acc  <= in_valid && !in_stall;
      out_acc <= out_valid && !out_stall;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          i2cmbw_pkg::REG_ADDRESS_BYTE: addr_cfg = cfg_data;
          i2cmbw_pkg::REG_DELAY_TICKS:  delay_cfg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_lines.size() == 0) begin
          $error("result with no tick pending: %b", out_data);
          fail_cnt++;
        end else begin
          e = expected_lines.pop_front();
          check_field("scl_release", e.scl_release, out_data.scl_release);
          check_field("sda_release", e.sda_release, out_data.sda_release);
          check_field("busy_res", e.busy_res, out_data.busy_res);
          check_field("no_ack", e.no_ack, out_data.no_ack);
          check_field("bus_fault", e.bus_fault, out_data.bus_fault);
          check_field("done_res", e.done_res, out_data.done_res);
        end
      end
      if (in_valid && !in_stall) expected_lines.push_back(predict_bus_tick(in_data));
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // Tick driver: hold the payload until transferred, then wait a random gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || in_acc) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_ticks.size() != 0) begin
        in_data  <= pending_ticks.pop_front();
        in_valid <= 1'b1;
        in_gap   <= $urandom_range(0, in_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall after each transfer, plus the long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        rx_hold   = LONG_HOLD;
      end
      if (out_acc) rx_wait = $urandom_range(0, out_gap_max);
      if (rx_hold != 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic i2cmbw_pkg::in_item_t make_tick(logic op, logic [3:0] tone, logic scl,
                                                     logic sda);
    i2cmbw_pkg::in_item_t t;
    t.opcode    = op;
    t.tone      = tone;
    t.scl_sense = scl;
    t.sda_sense = sda;
    return t;
  endfunction

  task automatic write_reg(logic [i2cmbw_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Feed plain ticks with SCL high until the sequencer is back to idle and
  // every result has been transferred; ack_level is what the slave drives.
  task automatic run_to_idle(logic ack_level);
    while (1) begin
      @(posedge clk);
      if (pending_ticks.size() == 0 && !in_valid) begin
        if (seq_ph != i2cmbw_pkg::PH_IDLE) begin
          repeat (4) pending_ticks.push_back(make_tick(i2cmbw_pkg::OP_TICK, 4'($urandom),
                                                       1'b1, ack_level));
        end else if (expected_lines.size() == 0) begin
          break;
        end
      end
    end
    repeat (3) @(posedge clk);
  endtask

  // Mostly well-formed writes with random content, some noise between them
  task automatic queue_writes(int n_ticks);
    int         left;
    int         len;
    int         eff;
    logic [3:0] tone;
    left = n_ticks;
    eff  = (delay_cfg == 8'd0) ? 1 : int'(delay_cfg);
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_ticks.push_back(i2cmbw_pkg::in_item_t'(7'($urandom)));
        left--;
      end else begin
        tone = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(0, 9));
        pending_ticks.push_back(make_tick(i2cmbw_pkg::OP_BEGIN, tone,
                                          $urandom_range(0, 9) != 0,
                                          $urandom_range(0, 9) != 0));
        len  = $urandom_range(20, 30 * (3 * eff + 2));
        left = left - 1 - len;
        repeat (len) begin
          pending_ticks.push_back(make_tick(($urandom_range(0, 19) == 0) ?
                                              i2cmbw_pkg::OP_BEGIN : i2cmbw_pkg::OP_TICK,
                                            4'($urandom), $urandom_range(0, 6) != 0,
                                            $urandom_range(0, 7) == 0));
        end
      end
    end
  endtask

  initial begin
    logic [7:0] addr_set[5];
    logic [7:0] delay_set[5];
    int         tick_set[5];
    addr_set  = '{8'h48, 8'h00, 8'hFF, 8'hA5, 8'h5A};
    delay_set = '{8'd1, 8'd0, 8'd2, 8'd3, 8'd1};
    tick_set  = '{100, 80, 80, 120, 100};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle tick, faults on each line, extreme tones, begin while busy
    pending_ticks.push_back(make_tick(i2cmbw_pkg::OP_TICK, 4'd0, 1'b0, 1'b0));
    pending_ticks.push_back(make_tick(i2cmbw_pkg::OP_BEGIN, 4'd0, 1'b0, 1'b1));
    pending_ticks.push_back(make_tick(i2cmbw_pkg::OP_BEGIN, 4'd0, 1'b1, 1'b0));
    pending_ticks.push_back(make_tick(i2cmbw_pkg::OP_BEGIN, 4'd9, 1'b0, 1'b0));
    pending_ticks.push_back(make_tick(i2cmbw_pkg::OP_BEGIN, 4'hF, 1'b1, 1'b1));
    pending_ticks.push_back(make_tick(i2cmbw_pkg::OP_BEGIN, 4'd9, 1'b1, 1'b1));
    repeat (6) pending_ticks.push_back(make_tick(i2cmbw_pkg::OP_TICK, 4'd0, 1'b0, 1'b0));
    run_to_idle(1'b0);
    // address refused by the slave
    pending_ticks.push_back(make_tick(i2cmbw_pkg::OP_BEGIN, 4'd9, 1'b1, 1'b1));
    run_to_idle(1'b1);

    write_reg(REG_SPARE_2, 8'hFF);
    write_reg(REG_SPARE_3, 8'h00);

    for (int p = 0; p < 5; p++) begin
      write_reg(i2cmbw_pkg::REG_ADDRESS_BYTE, addr_set[p]);
      write_reg(i2cmbw_pkg::REG_DELAY_TICKS, delay_set[p]);
      if (p == 4) begin
        in_gap_max  = 0;
        out_gap_max = 0;
      end
      queue_writes(tick_set[p]);
      if (p == 0) begin
        // stall the results while ticks keep coming
        repeat (40) @(posedge clk);
        hold_ask = ~hold_ask;
      end
      run_to_idle(1'($urandom_range(0, 1)));
      in_gap_max  = 10;
      out_gap_max = 10;
    end

    // longer hold, one write ended by a refused address
    write_reg(i2cmbw_pkg::REG_ADDRESS_BYTE, 8'h3C);
    write_reg(i2cmbw_pkg::REG_DELAY_TICKS, 8'd6);
    pending_ticks.push_back(make_tick(i2cmbw_pkg::OP_BEGIN, 4'd7, 1'b1, 1'b1));
    run_to_idle(1'b1);

    repeat (20) @(posedge clk);
    if (expected_lines.size() != 0) begin
      $error("%0d results never arrived", expected_lines.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/i2cmbw_pkg.sv
rtl/core/i2cmbw_step.sv
rtl/core/i2c_master_byte_writer.sv
tb/sv/tb.sv
